// ----- design/dcbw_pkg.sv -----
// Package for the display capture blend writer.
// Holds the register indexes, capture size tables and the channel blend function.
// Depends on nothing; used by display_capture_blend_writer.
package dcbw_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_A         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_B         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_SIZE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BLOCK      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_BANK_MAPPED = 3'd6;

  localparam logic [1:0] MODE_SOURCE_A = 2'd0;
  localparam logic [1:0] MODE_SOURCE_B = 2'd1;

  localparam logic [1:0] SIZE_128X128 = 2'd0;
  localparam logic [1:0] SIZE_256X64  = 2'd1;
  localparam logic [1:0] SIZE_256X128 = 2'd2;
  localparam logic [1:0] SIZE_256X192 = 2'd3;

  localparam logic [4:0] FACTOR_MAX = 5'd16;
  localparam logic [4:0] CH_MAX     = 5'h1F;

  function automatic logic [8:0] cap_width(input logic [1:0] size);
    logic [8:0] w;
    case (size)
      SIZE_128X128: w = 9'd128;
      default:      w = 9'd256;
    endcase
    return w;
  endfunction

  function automatic logic [8:0] cap_height(input logic [1:0] size);
    logic [8:0] h;
    case (size)
      SIZE_128X128: h = 9'd128;
      SIZE_256X64:  h = 9'd64;
      SIZE_256X128: h = 9'd128;
      SIZE_256X192: h = 9'd192;
      default:      h = 9'd128;
    endcase
    return h;
  endfunction

  function automatic logic [4:0] clamp_factor(input logic [4:0] k);
    return (k > FACTOR_MAX) ? FACTOR_MAX : k;
  endfunction

  // Weighted sum of two 5-bit channels divided by 16, rounded, then saturated to 31.
  function automatic logic [4:0] mix_channel(input logic [4:0] c1, input logic [4:0] w1,
                                             input logic [4:0] c2, input logic [4:0] w2);
    logic [9:0]  p1;
    logic [9:0]  p2;
    logic [10:0] sum;
    logic [6:0]  v;
    p1  = 10'(c1) * 10'(w1);
    p2  = 10'(c2) * 10'(w2);
    sum = 11'(p1) + 11'(p2) + 11'd8;
    v   = sum[10:4];
    return (v > 7'(CH_MAX)) ? CH_MAX : v[4:0];
  endfunction

endpackage

// ----- design/display_capture_blend_writer.sv -----
// Top level of the display capture blend writer: input register, blend and
// address logic, result register. Depends on dcbw_pkg.
//
//   channel   handshake              payload
//   --------  ---------------------  ----------------------------------------------
//   input     start / busy           column, line, a_red, a_green, a_blue,
//                                    a_alpha, b_word
//   result    done (one cycle)       write_strobe, write_offset, pixel_word
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock: busy stays low and an item may follow in every cycle.
// The result passes through the input register and then the result register
// before it appears.
// Reset clears the pipeline valid bits and all configuration registers.
// The receiver cannot stall, so done is simply the delayed accept.
module display_capture_blend_writer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [7:0]                     column,
  input  logic [7:0]                     line,
  input  logic [5:0]                     a_red,
  input  logic [5:0]                     a_green,
  input  logic [5:0]                     a_blue,
  input  logic [4:0]                     a_alpha,
  input  logic [15:0]                    b_word,
  output logic                           done,
  output logic                           write_strobe,
  output logic [16:0]                    write_offset,
  output logic [15:0]                    pixel_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dcbw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import dcbw_pkg::*;

  logic       capture_enable;
  logic [1:0] source_mode;
  logic [4:0] factor_a;
  logic [4:0] factor_b;
  logic [1:0] capture_size;
  logic [1:0] write_block;
  logic       dest_bank_mapped;

  logic        s1_valid;
  logic [7:0]  s1_column;
  logic [7:0]  s1_line;
  logic [4:0]  s1_r;
  logic [4:0]  s1_g;
  logic [4:0]  s1_b;
  logic        s1_alpha;
  logic [15:0] s1_b_word;

  logic        strobe_next;
  logic [16:0] offset_next;
  logic [15:0] pixel_next;
  logic [17:0] row_bytes;
  logic [17:0] offset_sum;
  logic [4:0]  w1;
  logic [4:0]  w2;
  logic        accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable   <= 1'b0;
      source_mode      <= 2'd0;
      factor_a         <= 5'd0;
      factor_b         <= 5'd0;
      capture_size     <= 2'd0;
      write_block      <= 2'd0;
      dest_bank_mapped <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAPTURE_ENABLE:   capture_enable   <= cfg_data[0];
        CFG_SOURCE_MODE:      source_mode      <= cfg_data[1:0];
        CFG_FACTOR_A:         factor_a         <= cfg_data[4:0];
        CFG_FACTOR_B:         factor_b         <= cfg_data[4:0];
        CFG_CAPTURE_SIZE:     capture_size     <= cfg_data[1:0];
        CFG_WRITE_BLOCK:      write_block      <= cfg_data[1:0];
        CFG_DEST_BANK_MAPPED: dest_bank_mapped <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register; source A is halved to 5-bit channels on the way in.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_column <= column;
      s1_line   <= line;
      s1_r      <= a_red[5:1];
      s1_g      <= a_green[5:1];
      s1_b      <= a_blue[5:1];
      s1_alpha  <= (a_alpha != 5'd0);
      s1_b_word <= b_word;
    end
  end

  always_comb begin
    strobe_next = capture_enable && dest_bank_mapped &&
                  ({1'b0, s1_column} < cap_width(capture_size)) &&
                  ({1'b0, s1_line} < cap_height(capture_size));

    // Two bytes per pixel, so a row is 256 or 512 bytes.
    if (capture_size == SIZE_128X128) begin
      row_bytes = {2'b00, s1_line, 8'd0};
    end else begin
      row_bytes = {1'b0, s1_line, 9'd0};
    end
    offset_sum = row_bytes + {1'b0, write_block, 15'd0} + {9'd0, s1_column, 1'b0};

    w1 = s1_alpha ? clamp_factor(factor_a) : 5'd0;
    w2 = s1_b_word[15] ? clamp_factor(factor_b) : 5'd0;

    case (source_mode)
      MODE_SOURCE_A: pixel_next = {s1_alpha, s1_b, s1_g, s1_r};
      MODE_SOURCE_B: pixel_next = s1_b_word;
      default: begin
        pixel_next = {(w1 != 5'd0) || (w2 != 5'd0),
                      mix_channel(s1_b, w1, s1_b_word[14:10], w2),
                      mix_channel(s1_g, w1, s1_b_word[9:5], w2),
                      mix_channel(s1_r, w1, s1_b_word[4:0], w2)};
      end
    endcase

    offset_next = offset_sum[16:0];
    if (!strobe_next) begin
      offset_next = 17'd0;
      pixel_next  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      write_strobe <= strobe_next;
      write_offset <= offset_next;
      pixel_word   <= pixel_next;
    end
  end

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted item produced no result two cycles later");

  a_done_needs_stage: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_valid))
    else $error("result shown without an item in the input register");

  a_strobe_gated: assert property (@(posedge clk) disable iff (rst)
    (done && write_strobe) |-> (capture_enable && dest_bank_mapped))
    else $error("write strobe while capture is off or bank unmapped");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !write_strobe) |-> (write_offset == 17'd0 && pixel_word == 16'd0))
    else $error("suppressed write carries nonzero fields");

  a_offset_even: assert property (@(posedge clk) disable iff (rst)
    done |-> (write_offset[0] == 1'b0))
    else $error("pixel offset is not halfword aligned");

endmodule

// ----- bench/display_capture_blend_writer_test.sv -----
// Testbench for display_capture_blend_writer: directed and random pixels under many
// capture settings, each result checked against an in-bench model of the capture write.
// Depends on dcbw_pkg and the display_capture_blend_writer RTL only.
module display_capture_blend_writer_test;
  import dcbw_pkg::*;

  localparam logic [1:0] MODE_BLEND     = 2'd2;
  localparam logic [1:0] MODE_BLEND_ALT = 2'd3;
  localparam int         CYCLE_LIMIT    = 100000;
  localparam int         FRAME_COUNT    = 27;
  localparam int         PIXELS_PER_FRAME = 50;

  typedef struct packed {
    logic        strobe;
    logic [16:0] offset;
    logic [15:0] pixel;
  } capture_write_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [7:0]           column = '0;
  logic [7:0]           line = '0;
  logic [5:0]           a_red = '0;
  logic [5:0]           a_green = '0;
  logic [5:0]           a_blue = '0;
  logic [4:0]           a_alpha = '0;
  logic [15:0]          b_word = '0;
  logic                 done;
  logic                 write_strobe;
  logic [16:0]          write_offset;
  logic [15:0]          pixel_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  // Bench copy of the capture registers, all zero after reset.
  logic       cap_enable  = 1'b0;
  logic [1:0] src_mode    = '0;
  logic [4:0] weight_a    = '0;
  logic [4:0] weight_b    = '0;
  logic [1:0] cap_size    = '0;
  logic [1:0] start_block = '0;
  logic       bank_mapped = 1'b0;

  capture_write_t pending_writes[$];
  int             mismatch_count = 0;
  int             cycle_count = 0;

  display_capture_blend_writer uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .column(column), .line(line), .a_red(a_red), .a_green(a_green), .a_blue(a_blue),
    .a_alpha(a_alpha), .b_word(b_word), .done(done), .write_strobe(write_strobe),
    .write_offset(write_offset), .pixel_word(pixel_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d writes outstanding", $time, pending_writes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [4:0] blend_channel(input logic [4:0] c1, input int w1,
                                               input logic [4:0] c2, input int w2);
    int v;
    v = (int'(c1) * w1 + int'(c2) * w2 + 8) >> 4;
    return (v > 31) ? 5'h1F : 5'(v);
  endfunction

  function automatic capture_write_t predict_capture_write(
      input logic [7:0] col, input logic [7:0] ln, input logic [5:0] r6,
      input logic [5:0] g6, input logic [5:0] b6, input logic [4:0] al,
      input logic [15:0] bw);
    capture_write_t res;
    int width, height, ka, kb, wa, wb;
    logic aa;
    res = '0;
    width = (cap_size == SIZE_128X128) ? 128 : 256;
    case (cap_size)
      SIZE_256X64:  height = 64;
      SIZE_256X192: height = 192;
      default:      height = 128;
    endcase
    if (cap_enable && bank_mapped && int'(col) < width && int'(ln) < height) begin
      res.strobe = 1'b1;
      res.offset = 17'(int'(ln) * width * 2 + int'(start_block) * 32'h8000 + int'(col) * 2);
      aa = (al != 5'd0);
      case (src_mode)
        MODE_SOURCE_A: res.pixel = {aa, b6[5:1], g6[5:1], r6[5:1]};
        MODE_SOURCE_B: res.pixel = bw;
        default: begin
          ka = (weight_a > 5'd16) ? 16 : int'(weight_a);
          kb = (weight_b > 5'd16) ? 16 : int'(weight_b);
          wa = aa ? ka : 0;
          wb = bw[15] ? kb : 0;
          res.pixel = {(wa != 0 || wb != 0),
                       blend_channel(b6[5:1], wa, bw[14:10], wb),
                       blend_channel(g6[5:1], wa, bw[9:5], wb),
                       blend_channel(r6[5:1], wa, bw[4:0], wb)};
        end
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    capture_write_t want;
    if (!rst && done) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: result with no pixel pending: strobe %0d offset %h pixel %h",
                 $time, write_strobe, write_offset, pixel_word);
        mismatch_count++;
      end else begin
        want = pending_writes.pop_front();
        if (write_strobe !== want.strobe) begin
          $display("%0t: write_strobe expected %0d actual %0d", $time, want.strobe,
                   write_strobe);
          mismatch_count++;
        end
        if (write_offset !== want.offset) begin
          $display("%0t: write_offset expected %h actual %h", $time, want.offset,
                   write_offset);
          mismatch_count++;
        end
        if (pixel_word !== want.pixel) begin
          $display("%0t: pixel_word expected %h actual %h", $time, want.pixel, pixel_word);
          mismatch_count++;
        end
      end
    end
  end

  // Leaves start high so that a following item can go out in the next cycle.
  task automatic send_pixel(input logic [7:0] col, input logic [7:0] ln, input logic [5:0] r6,
                            input logic [5:0] g6, input logic [5:0] b6, input logic [4:0] al,
                            input logic [15:0] bw, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    column  <= col;
    line    <= ln;
    a_red   <= r6;
    a_green <= g6;
    a_blue  <= b6;
    a_alpha <= al;
    b_word  <= bw;
    do @(posedge clk); while (busy);
    pending_writes.push_back(predict_capture_write(col, ln, r6, g6, b6, al, bw));
  endtask

  task automatic drain_pixels();
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_capture_setting(input logic en, input logic [1:0] mode,
                                       input logic [4:0] fa, input logic [4:0] fb,
                                       input logic [1:0] size, input logic [1:0] blk,
                                       input logic mapped);
    drain_pixels();
    write_register(CFG_CAPTURE_ENABLE, 16'(en));
    write_register(CFG_SOURCE_MODE, 16'(mode));
    write_register(CFG_FACTOR_A, 16'(fa));
    write_register(CFG_FACTOR_B, 16'(fb));
    write_register(CFG_CAPTURE_SIZE, 16'(size));
    write_register(CFG_WRITE_BLOCK, 16'(blk));
    write_register(CFG_DEST_BANK_MAPPED, 16'(mapped));
    cfg_valid   <= 1'b0;
    cap_enable  = en;
    src_mode    = mode;
    weight_a    = fa;
    weight_b    = fb;
    cap_size    = size;
    start_block = blk;
    bank_mapped = mapped;
  endtask

  function automatic logic [4:0] pick_factor();
    case ($urandom_range(0, 3))
      0:       return 5'd0;
      1:       return 5'd16;
      2:       return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // Registers still at reset: capture is off, so nothing may be written.
  task automatic test_reset_state();
    send_pixel(8'd0, 8'd0, 6'd63, 6'd63, 6'd63, 5'd31, 16'hFFFF, 1'b1);
    send_pixel(8'd10, 8'd20, 6'd5, 6'd6, 6'd7, 5'd1, 16'h1234, 1'b0);
  endtask

  task automatic test_source_a_window();
    apply_capture_setting(1'b1, MODE_SOURCE_A, 5'd0, 5'd0, SIZE_128X128, 2'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 6'd0, 6'd0, 6'd0, 5'd0, 16'hFFFF, 1'b1);
    send_pixel(8'd127, 8'd127, 6'd63, 6'd63, 6'd63, 5'd31, 16'h0000, 1'b1);
    send_pixel(8'd128, 8'd0, 6'd33, 6'd21, 6'd42, 5'd16, 16'h0000, 1'b0);
    send_pixel(8'd0, 8'd128, 6'd33, 6'd21, 6'd42, 5'd16, 16'h0000, 1'b0);
    send_pixel(8'd255, 8'd191, 6'd63, 6'd63, 6'd63, 5'd31, 16'hFFFF, 1'b0);
  endtask

  // The last pixel of a 256x192 capture in block 3 wraps past the end of the bank.
  task automatic test_source_b_wrap();
    apply_capture_setting(1'b1, MODE_SOURCE_B, 5'd31, 5'd31, SIZE_256X192, 2'd3, 1'b1);
    send_pixel(8'd255, 8'd191, 6'd0, 6'd0, 6'd0, 5'd0, 16'hFFFF, 1'b1);
    send_pixel(8'd0, 8'd0, 6'd63, 6'd63, 6'd63, 5'd31, 16'h0000, 1'b0);
    send_pixel(8'd128, 8'd64, 6'd1, 6'd2, 6'd3, 5'd1, 16'h8000, 1'b0);
  endtask

  task automatic test_blend_saturation();
    apply_capture_setting(1'b1, MODE_BLEND, 5'd16, 5'd16, SIZE_256X64, 2'd1, 1'b1);
    send_pixel(8'd255, 8'd63, 6'd63, 6'd63, 6'd63, 5'd31, 16'hFFFF, 1'b1);
    send_pixel(8'd17, 8'd5, 6'd63, 6'd63, 6'd63, 5'd0, 16'h7FFF, 1'b1);
    send_pixel(8'd0, 8'd64, 6'd63, 6'd63, 6'd63, 5'd1, 16'hFFFF, 1'b0);
    send_pixel(8'd3, 8'd1, 6'd40, 6'd2, 6'd63, 5'd1, 16'h0000, 1'b0);
  endtask

  // Factors above 16 act as 16; mode 3 blends like mode 2; zero factors drop alpha.
  task automatic test_blend_clamp_and_alpha();
    apply_capture_setting(1'b1, MODE_BLEND_ALT, 5'd31, 5'd17, SIZE_256X128, 2'd2, 1'b1);
    send_pixel(8'd200, 8'd127, 6'd40, 6'd20, 6'd10, 5'd2, 16'h0000, 1'b1);
    send_pixel(8'd1, 8'd2, 6'd0, 6'd0, 6'd0, 5'd0, 16'hAB6D, 1'b0);
    apply_capture_setting(1'b1, MODE_BLEND, 5'd0, 5'd0, SIZE_256X128, 2'd0, 1'b1);
    send_pixel(8'd9, 8'd9, 6'd63, 6'd63, 6'd63, 5'd31, 16'hFFFF, 1'b0);
    apply_capture_setting(1'b1, MODE_BLEND, 5'd5, 5'd11, SIZE_128X128, 2'd1, 1'b1);
    send_pixel(8'd100, 8'd50, 6'd40, 6'd41, 6'd13, 5'd4, 16'h9CE7, 1'b1);
    send_pixel(8'd64, 8'd100, 6'd62, 6'd1, 6'd30, 5'd8, 16'h8421, 1'b0);
  endtask

  task automatic test_strobe_gating();
    apply_capture_setting(1'b0, MODE_SOURCE_B, 5'd16, 5'd16, SIZE_256X192, 2'd0, 1'b1);
    send_pixel(8'd5, 8'd5, 6'd1, 6'd1, 6'd1, 5'd1, 16'h5555, 1'b0);
    apply_capture_setting(1'b1, MODE_SOURCE_B, 5'd16, 5'd16, SIZE_256X192, 2'd0, 1'b0);
    send_pixel(8'd5, 8'd5, 6'd1, 6'd1, 6'd1, 5'd1, 16'hAAAA, 1'b0);
  endtask

  // Random capture settings per frame; most pixels fall inside the capture window.
  task automatic test_random_frames();
    int   frame, n, width, height;
    bit   burst;
    logic [7:0] col, ln;
    for (frame = 0; frame < FRAME_COUNT; frame++) begin
      apply_capture_setting(($urandom_range(0, 7) != 0), 2'($urandom_range(0, 3)),
                            pick_factor(), pick_factor(), 2'($urandom_range(0, 3)),
                            2'($urandom_range(0, 3)), ($urandom_range(0, 7) != 0));
      width  = (cap_size == SIZE_128X128) ? 128 : 256;
      height = (cap_size == SIZE_256X64) ? 64 : (cap_size == SIZE_256X192) ? 192 : 128;
      burst  = (frame % 3 == 0);
      for (n = 0; n < PIXELS_PER_FRAME; n++) begin
        if ($urandom_range(0, 4) != 0) begin
          col = 8'($urandom_range(0, width - 1));
          ln  = 8'($urandom_range(0, height - 1));
        end else begin
          col = 8'($urandom_range(0, 255));
          ln  = 8'($urandom_range(0, 191));
        end
        send_pixel(col, ln, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)),
                   ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(0, 31)),
                   16'($urandom), burst);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_source_a_window();
    test_source_b_wrap();
    test_blend_saturation();
    test_blend_clamp_and_alpha();
    test_strobe_gating();
    test_random_frames();
    drain_pixels();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
